// File: hdl/paff_pkg.sv
// paff_pkg: shared types, constants and arithmetic helpers for the planar
// affine transform (mix, divide by five, arctangent table).
// No dependencies.
`timescale 1ns / 1ps

package paff_pkg;

    // register indexes on the configuration port, also mix lane numbers
    typedef enum logic [2:0] {
        REG_TX     = 3'd0,
        REG_TY     = 3'd1,
        REG_SX     = 3'd2,
        REG_SY     = 3'd3,
        REG_KX     = 3'd4,
        REG_KY     = 3'd5,
        REG_ROT    = 3'd6,
        REG_DEPTHS = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

    localparam int NUM_MIX   = 7;
    localparam int CW        = 44;   // cordic datapath width, 16 fraction bits
    localparam int FRAC      = 16;

    typedef logic signed [16:0] t_base;
    typedef logic signed [15:0] t_cv;
    typedef logic [8:0]         t_depth;
    typedef logic signed [25:0] t_mix;
    typedef logic signed [25:0] t_pt;
    typedef logic signed [51:0] t_prod;
    typedef logic signed [27:0] t_quo;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [31:0]   z;
    } t_cordic;

    localparam logic [29:0] DIV5_OFFSET = 30'd671088640;  // 5 * 2^27
    localparam logic [27:0] DIV5_MUL    = 28'd214748365;  // ceil(2^30 / 5)
    localparam logic [27:0] DIV5_BIAS   = 28'h800_0000;
    localparam logic signed [31:0] FIVE_VOLT = 32'sd2621440;
    localparam logic signed [15:0] GAIN_HI   = 16'sd19898;  // gain >> 15
    localparam logic signed [15:0] GAIN_LO   = 16'sd15210;  // gain & 0x7fff

    // m = base*(256-d) + cv*d, d already limited to 256
    function automatic t_mix mix(input t_base b, input t_depth d, input t_cv cv);
        logic signed [9:0] ws;
        logic signed [9:0] ds;
        ws = signed'({1'b0, 9'(9'd256 - d)});
        ds = signed'({1'b0, d});
        return 26'(27'(b * ws) + 27'(cv * ds));
    endfunction

    // floor(v / 5) by reciprocal multiply, exact for |v| < 2^27
    function automatic t_quo div5_floor(input t_quo v);
        logic [29:0] u;
        logic [57:0] p;
        u = 30'({{2{v[27]}}, v}) + DIV5_OFFSET;
        p = 58'(u) * 58'(DIV5_MUL);
        return signed'(28'(p[57:30] - DIV5_BIAS));
    endfunction

    // round(prod / 2621440), halves up
    function automatic t_quo div_five_volt(input t_prod prod);
        return div5_floor(28'((prod + 52'sd1310720) >>> 19));
    endfunction

    // floor((t * 8192 + 2) / 5) for the phase remainder t
    function automatic logic [12:0] phase_frac(input logic [2:0] t);
        logic [12:0] r;
        unique case (t)
            3'd1:    r = 13'd1638;
            3'd2:    r = 13'd3277;
            3'd3:    r = 13'd4915;
            3'd4:    r = 13'd6554;
            default: r = 13'd0;
        endcase
        return r;
    endfunction

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [29:0] atan_turns(input int i);
        logic [29:0] r;
        unique case (i)
            0:  r = 30'd536870912;
            1:  r = 30'd316933406;
            2:  r = 30'd167458907;
            3:  r = 30'd85004756;
            4:  r = 30'd42667331;
            5:  r = 30'd21354465;
            6:  r = 30'd10679838;
            7:  r = 30'd5340245;
            8:  r = 30'd2670163;
            9:  r = 30'd1335087;
            10: r = 30'd667544;
            11: r = 30'd333772;
            12: r = 30'd166886;
            13: r = 30'd83443;
            14: r = 30'd41722;
            15: r = 30'd20861;
            16: r = 30'd10430;
            17: r = 30'd5215;
            18: r = 30'd2608;
            19: r = 30'd1304;
            20: r = 30'd652;
            21: r = 30'd326;
            22: r = 30'd163;
            23: r = 30'd81;
            24: r = 30'd41;
            25: r = 30'd20;
            26: r = 30'd10;
            27: r = 30'd5;
            28: r = 30'd3;
            29: r = 30'd1;
            30: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/paff_front.sv
// paff_front: mix, translate, scale, shear, rotation phase, gain and
// quadrant fold; eleven register stages feeding the cordic cell chain.
// Depends on paff_pkg.
`timescale 1ns / 1ps

module paff_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [15:0]  i_x,
    input  logic signed [15:0]  i_y,
    input  paff_pkg::t_cv       i_cv    [paff_pkg::NUM_MIX],
    input  paff_pkg::t_base     i_base  [paff_pkg::NUM_MIX],
    input  paff_pkg::t_depth    i_depth [paff_pkg::NUM_MIX],
    output logic                o_valid,
    output paff_pkg::t_cordic   o_data
);

    logic [10:0] r_vld;

    paff_pkg::t_pt   r_a_x, r_a_y;
    paff_pkg::t_mix  r_a_m [paff_pkg::NUM_MIX];

    paff_pkg::t_pt   r_b_x1, r_b_y1;
    paff_pkg::t_mix  r_b_m2, r_b_m3, r_b_m4, r_b_m5, r_b_m6;
    paff_pkg::t_quo  r_b_qd;

    paff_pkg::t_prod r_c_px, r_c_py;
    paff_pkg::t_mix  r_c_m4, r_c_m5;
    logic [21:0]     r_c_p;

    paff_pkg::t_pt   r_d_x2, r_d_y2;
    paff_pkg::t_mix  r_d_m4, r_d_m5;
    logic [21:0]     r_d_p;
    logic [18:0]     r_d_k;

    paff_pkg::t_prod r_e_pk;
    paff_pkg::t_pt   r_e_x2, r_e_y2;
    paff_pkg::t_mix  r_e_m5;
    logic [31:0]     r_e_beta;

    paff_pkg::t_pt   r_f_x3, r_f_y2;
    paff_pkg::t_mix  r_f_m5;
    paff_pkg::t_quad r_f_quad;
    logic signed [31:0] r_f_z;

    paff_pkg::t_prod r_g_pk;
    paff_pkg::t_pt   r_g_x3, r_g_y2;
    paff_pkg::t_quad r_g_quad;
    logic signed [31:0] r_g_z;

    paff_pkg::t_pt   r_h_x3, r_h_y3;
    paff_pkg::t_quad r_h_quad;
    logic signed [31:0] r_h_z;

    logic signed [41:0] r_i_xh, r_i_xl, r_i_yh, r_i_yl;
    paff_pkg::t_quad r_i_quad;
    logic signed [31:0] r_i_z;

    logic signed [paff_pkg::CW-1:0] r_j_xg, r_j_yg;
    paff_pkg::t_quad r_j_quad;
    logic signed [31:0] r_j_z;

    paff_pkg::t_cordic r_k;

    logic signed [31:0] n_pw;
    paff_pkg::t_quo     n_k;
    logic [2:0]         n_t;
    logic [31:0]        n_a;
    logic [1:0]         n_q;
    logic [29:0]        n_r;
    paff_pkg::t_cordic  n_k_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[9:0], i_valid};
        end
    end

    // phase and quadrant helpers
    always_comb begin
        n_pw = 32'(r_b_m6) - 32'(r_b_qd) * paff_pkg::FIVE_VOLT;
        n_k  = paff_pkg::div5_floor(28'({6'b0, r_c_p}));
        n_t  = 3'(r_d_p - 22'({3'b0, r_d_k}) * 22'd5);
        n_a  = {r_d_k, 13'b0} + 32'(paff_pkg::phase_frac(n_t));
        n_q  = r_e_beta[31:30];
        n_r  = r_e_beta[29:0];
    end

    // whole quarter turns are exact swaps and negations
    always_comb begin
        n_k_d.z = r_j_z;
        unique case (r_j_quad)
            paff_pkg::QUAD_0: begin
                n_k_d.x = r_j_xg;
                n_k_d.y = r_j_yg;
            end
            paff_pkg::QUAD_90: begin
                n_k_d.x = -r_j_yg;
                n_k_d.y = r_j_xg;
            end
            paff_pkg::QUAD_180: begin
                n_k_d.x = -r_j_xg;
                n_k_d.y = -r_j_yg;
            end
            paff_pkg::QUAD_270: begin
                n_k_d.x = r_j_yg;
                n_k_d.y = -r_j_xg;
            end
            default: begin
                n_k_d.x = r_j_xg;
                n_k_d.y = r_j_yg;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        // A: mixes
        r_a_x <= 26'(i_x);
        r_a_y <= 26'(i_y);
        for (int k = 0; k < paff_pkg::NUM_MIX; k++) begin
            r_a_m[k] <= paff_pkg::mix(i_base[k], i_depth[k], i_cv[k]);
        end
        // B: translate, coarse turn count
        r_b_x1 <= 26'(r_a_x + ((r_a_m[paff_pkg::REG_TX] + 26'sd128) >>> 8));
        r_b_y1 <= 26'(r_a_y + ((r_a_m[paff_pkg::REG_TY] + 26'sd128) >>> 8));
        r_b_m2 <= r_a_m[paff_pkg::REG_SX];
        r_b_m3 <= r_a_m[paff_pkg::REG_SY];
        r_b_m4 <= r_a_m[paff_pkg::REG_KX];
        r_b_m5 <= r_a_m[paff_pkg::REG_KY];
        r_b_m6 <= r_a_m[paff_pkg::REG_ROT];
        r_b_qd <= paff_pkg::div5_floor(28'(r_a_m[paff_pkg::REG_ROT] >>> 19));
        // C: scale products, phase modulo one turn
        r_c_px <= 52'(r_b_x1 * r_b_m2);
        r_c_py <= 52'(r_b_y1 * r_b_m3);
        r_c_m4 <= r_b_m4;
        r_c_m5 <= r_b_m5;
        r_c_p  <= n_pw[21:0];
        // D
        r_d_x2 <= 26'(paff_pkg::div_five_volt(r_c_px));
        r_d_y2 <= 26'(paff_pkg::div_five_volt(r_c_py));
        r_d_m4 <= r_c_m4;
        r_d_m5 <= r_c_m5;
        r_d_p  <= r_c_p;
        r_d_k  <= n_k[18:0];
        // E: shear x product, clockwise angle
        r_e_pk   <= 52'(r_d_y2 * r_d_m4);
        r_e_x2   <= r_d_x2;
        r_e_y2   <= r_d_y2;
        r_e_m5   <= r_d_m5;
        r_e_beta <= 32'd0 - n_a;
        // F
        r_f_x3 <= 26'(r_e_x2 + 26'(paff_pkg::div_five_volt(r_e_pk)));
        r_f_y2 <= r_e_y2;
        r_f_m5 <= r_e_m5;
        if (n_r >= 30'h2000_0000) begin
            r_f_quad <= paff_pkg::t_quad'(2'(n_q + 2'd1));
            r_f_z    <= signed'({2'b0, n_r}) - 32'sh4000_0000;
        end else begin
            r_f_quad <= paff_pkg::t_quad'(n_q);
            r_f_z    <= signed'({2'b0, n_r});
        end
        // G: shear y uses the new x
        r_g_pk   <= 52'(r_f_x3 * r_f_m5);
        r_g_x3   <= r_f_x3;
        r_g_y2   <= r_f_y2;
        r_g_quad <= r_f_quad;
        r_g_z    <= r_f_z;
        // H
        r_h_x3   <= r_g_x3;
        r_h_y3   <= 26'(r_g_y2 + 26'(paff_pkg::div_five_volt(r_g_pk)));
        r_h_quad <= r_g_quad;
        r_h_z    <= r_g_z;
        // I: gain split into two 15-bit halves
        r_i_xh   <= 42'(r_h_x3 * paff_pkg::GAIN_HI);
        r_i_xl   <= 42'(r_h_x3 * paff_pkg::GAIN_LO);
        r_i_yh   <= 42'(r_h_y3 * paff_pkg::GAIN_HI);
        r_i_yl   <= 42'(r_h_y3 * paff_pkg::GAIN_LO);
        r_i_quad <= r_h_quad;
        r_i_z    <= r_h_z;
        // J
        r_j_xg   <= paff_pkg::CW'(((58'(r_i_xh) <<< 15) + 58'(r_i_xl)) >>> 14);
        r_j_yg   <= paff_pkg::CW'(((58'(r_i_yh) <<< 15) + 58'(r_i_yl)) >>> 14);
        r_j_quad <= r_i_quad;
        r_j_z    <= r_i_z;
        // K
        r_k      <= n_k_d;
    end

    assign o_valid = r_vld[10];
    assign o_data  = r_k;

endmodule

// File: hdl/paff_cell.sv
// paff_cell: one cordic micro-rotation, registered; identical cells form
// the rotation chain. Depends on paff_pkg.
`timescale 1ns / 1ps

module paff_cell #(
    parameter int STAGE = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  paff_pkg::t_cordic i_data,
    output logic              o_valid,
    output paff_pkg::t_cordic o_data
);

    localparam logic signed [31:0] ATAN = signed'({2'b0, paff_pkg::atan_turns(STAGE)});

    logic              r_vld;
    paff_pkg::t_cordic r_d;
    paff_pkg::t_cordic n_d;
    logic signed [paff_pkg::CW-1:0] dx, dy;

    always_comb begin
        dx = i_data.x >>> STAGE;
        dy = i_data.y >>> STAGE;
        if (i_data.z >= 0) begin
            n_d.x = i_data.x - dy;
            n_d.y = i_data.y + dx;
            n_d.z = i_data.z - ATAN;
        end else begin
            n_d.x = i_data.x + dy;
            n_d.y = i_data.y - dx;
            n_d.z = i_data.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_valid = r_vld;
    assign o_data  = r_d;

endmodule

// File: hdl/planar_affine_transform.sv
// planar_affine_transform: top level with configuration registers, front
// pipeline, cordic cell chain and output rounding. Depends on paff_pkg,
// paff_front, paff_cell.
// One item per cycle, set by the fully pipelined front stages and one cell
// per rotation. busy stays low; results cannot be stalled and appear for one
// cycle. Reset clears the pipeline valid bits and returns registers to
// defaults.
`timescale 1ns / 1ps

module planar_affine_transform #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int ROTATION_STAGES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic signed [15:0]      i_x_in,
    input  logic signed [15:0]      i_y_in,
    input  logic signed [15:0]      i_translate_x_cv,
    input  logic signed [15:0]      i_translate_y_cv,
    input  logic signed [15:0]      i_scale_x_cv,
    input  logic signed [15:0]      i_scale_y_cv,
    input  logic signed [15:0]      i_skew_x_cv,
    input  logic signed [15:0]      i_skew_y_cv,
    input  logic signed [15:0]      i_rotate_cv,
    output logic                    o_done,
    output logic signed [SAMPLE_WIDTH-1:0] o_x_out,
    output logic signed [SAMPLE_WIDTH-1:0] o_y_out,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [62:0]             i_cfg_data
);

    localparam int RW = paff_pkg::CW - paff_pkg::FRAC;
    localparam logic signed [63:0] OUT_HI = 64'sd2 ** (SAMPLE_WIDTH - 1) - 64'sd1;
    localparam logic signed [63:0] OUT_LO = -OUT_HI - 64'sd1;

    paff_pkg::t_base  r_base [paff_pkg::NUM_MIX];
    logic [62:0]      r_depths;
    paff_pkg::t_depth dep  [paff_pkg::NUM_MIX];
    paff_pkg::t_cv    cvs  [paff_pkg::NUM_MIX];

    logic              front_vld;
    paff_pkg::t_cordic front_d;
    logic              c_vld [ROTATION_STAGES+1];
    paff_pkg::t_cordic c_d   [ROTATION_STAGES+1];

    logic signed [RW-1:0]  rx, ry;
    logic signed [63:0]    wx, wy;
    logic                  r_done;
    logic signed [SAMPLE_WIDTH-1:0] r_x_out, r_y_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base[paff_pkg::REG_TX]  <= '0;
            r_base[paff_pkg::REG_TY]  <= '0;
            r_base[paff_pkg::REG_SX]  <= 17'sd10240;
            r_base[paff_pkg::REG_SY]  <= 17'sd10240;
            r_base[paff_pkg::REG_KX]  <= '0;
            r_base[paff_pkg::REG_KY]  <= '0;
            r_base[paff_pkg::REG_ROT] <= '0;
            r_depths                  <= '0;
        end else if (i_cfg_valid) begin
            unique case (paff_pkg::t_reg_idx'(i_cfg_index))
                paff_pkg::REG_TX, paff_pkg::REG_TY,
                paff_pkg::REG_KX, paff_pkg::REG_KY: begin
                    r_base[i_cfg_index] <= signed'({{2{i_cfg_data[14]}}, i_cfg_data[14:0]});
                end
                paff_pkg::REG_SX, paff_pkg::REG_SY: begin
                    r_base[i_cfg_index] <= signed'({2'b0, i_cfg_data[14:0]});
                end
                paff_pkg::REG_ROT: begin
                    r_base[paff_pkg::REG_ROT] <= signed'({3'b0, i_cfg_data[13:0]});
                end
                paff_pkg::REG_DEPTHS: begin
                    r_depths <= i_cfg_data;
                end
                default: begin
                    r_depths <= r_depths;
                end
            endcase
        end
    end

    // depth above one counts as one
    always_comb begin
        for (int k = 0; k < paff_pkg::NUM_MIX; k++) begin
            dep[k] = (r_depths[9*k +: 9] > 9'd256) ? 9'd256 : r_depths[9*k +: 9];
        end
        cvs[paff_pkg::REG_TX]  = i_translate_x_cv;
        cvs[paff_pkg::REG_TY]  = i_translate_y_cv;
        cvs[paff_pkg::REG_SX]  = i_scale_x_cv;
        cvs[paff_pkg::REG_SY]  = i_scale_y_cv;
        cvs[paff_pkg::REG_KX]  = i_skew_x_cv;
        cvs[paff_pkg::REG_KY]  = i_skew_y_cv;
        cvs[paff_pkg::REG_ROT] = i_rotate_cv;
    end

    paff_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start),
        .i_x     (i_x_in),
        .i_y     (i_y_in),
        .i_cv    (cvs),
        .i_base  (r_base),
        .i_depth (dep),
        .o_valid (front_vld),
        .o_data  (front_d)
    );

    assign c_vld[0] = front_vld;
    assign c_d[0]   = front_d;

    for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_cell
        paff_cell #(.STAGE(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_vld[g]),
            .i_data  (c_d[g]),
            .o_valid (c_vld[g+1]),
            .o_data  (c_d[g+1])
        );
    end

    // round off the fraction bits, then clamp
    always_comb begin
        rx = RW'((c_d[ROTATION_STAGES].x + paff_pkg::CW'(32768)) >>> paff_pkg::FRAC);
        ry = RW'((c_d[ROTATION_STAGES].y + paff_pkg::CW'(32768)) >>> paff_pkg::FRAC);
        wx = 64'(rx);
        wy = 64'(ry);
        if (wx > OUT_HI) begin
            wx = OUT_HI;
        end else if (wx < OUT_LO) begin
            wx = OUT_LO;
        end
        if (wy > OUT_HI) begin
            wy = OUT_HI;
        end else if (wy < OUT_LO) begin
            wy = OUT_LO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= c_vld[ROTATION_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x_out <= SAMPLE_WIDTH'(wx);
        r_y_out <= SAMPLE_WIDTH'(wy);
    end

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_x_out     = r_x_out;
    assign o_y_out     = r_y_out;

endmodule

// File: bench/tb.sv
// tb: self-checking bench for planar_affine_transform; drives points at random
// rates across several register settings and checks every result.
// Depends on paff_pkg and the planar_affine_transform RTL.
`timescale 1ns / 1ps

module tb;

    localparam longint FIVE_V   = 2621440;
    localparam int     LATENCY  = 12 + 16;

    typedef struct {
        logic signed [15:0] x, y, tx, ty, sx, sy, kx, ky, rot;
    } t_point_item;

    // holds the register copy, computes expected points, checks results
    class affine_scoreboard;
        longint            base[7];
        bit [62:0]         depths;
        logic signed [15:0] exp_x[$];
        logic signed [15:0] exp_y[$];
        int                errors;
        longint            atan_q[16] = '{536870912, 316933406, 167458907, 85004756,
            42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
            333772, 166886, 83443, 41722, 20861};

        function new();
            base = '{0, 0, 10240, 10240, 0, 0, 0};
            depths = '0;
            errors = 0;
        endfunction

        function void write_reg(paff_pkg::t_reg_idx idx, bit [62:0] v);
            case (idx)
                paff_pkg::REG_TX, paff_pkg::REG_TY, paff_pkg::REG_KX, paff_pkg::REG_KY:
                    base[idx] = longint'($signed(v[14:0]));
                paff_pkg::REG_SX, paff_pkg::REG_SY:
                    base[idx] = longint'({1'b0, v[14:0]});
                paff_pkg::REG_ROT:
                    base[idx] = longint'({1'b0, v[13:0]});
                paff_pkg::REG_DEPTHS:
                    depths = v;
                default: ;
            endcase
        endfunction

        function longint floor_shift(longint v, int n);
            return v >>> n;
        endfunction

        function longint floor_div(longint p, longint d);
            if (p >= 0) return p / d;
            return -((-p + d - 1) / d);
        endfunction

        function longint round_div(longint p, longint d);
            return floor_div(p + d / 2, d);
        endfunction

        function longint mixed_amount(int k, logic signed [15:0] cv);
            longint d;
            d = longint'((depths >> (9 * k)) & 63'd511);
            if (d > 256) d = 256;
            return base[k] * (256 - d) + longint'(cv) * d;
        endfunction

        function logic signed [15:0] clamp16(longint v);
            if (v > 32767) return 16'sh7fff;
            if (v < -32768) return 16'sh8000;
            return 16'(v);
        endfunction

        function void note_item(t_point_item it);
            longint x, y, t, p, z, dx, dy;
            bit [63:0] wide;
            bit [31:0] ang, beta;
            bit [1:0]  quad;
            bit [29:0] rem;
            x = longint'(it.x) + round_div(mixed_amount(0, it.tx), 256);
            y = longint'(it.y) + round_div(mixed_amount(1, it.ty), 256);
            x = round_div(x * mixed_amount(2, it.sx), FIVE_V);
            y = round_div(y * mixed_amount(3, it.sy), FIVE_V);
            x = x + round_div(y * mixed_amount(4, it.kx), FIVE_V);
            y = y + round_div(x * mixed_amount(5, it.ky), FIVE_V);
            p = mixed_amount(6, it.rot);
            p = p - floor_div(p, FIVE_V) * FIVE_V;
            wide = ((64'(p) << 32) + 64'(FIVE_V / 2)) / 64'(FIVE_V);
            ang = wide[31:0];
            beta = 32'd0 - ang;
            x = floor_shift(x * 652032874, 14);
            y = floor_shift(y * 652032874, 14);
            quad = beta[31:30];
            rem = beta[29:0];
            if (rem >= 30'h2000_0000) begin
                quad = quad + 2'd1;
                z = longint'(rem) - 64'sh4000_0000;
            end else begin
                z = longint'(rem);
            end
            case (quad)
                2'd1: begin t = x; x = -y; y = t; end
                2'd2: begin x = -x; y = -y; end
                2'd3: begin t = x; x = y; y = -t; end
                default: ;
            endcase
            for (int i = 0; i < 16; i++) begin
                dx = floor_shift(y, i);
                dy = floor_shift(x, i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_q[i];
                end else begin
                    x += dx; y -= dy; z += atan_q[i];
                end
            end
            exp_x.push_back(clamp16(floor_shift(x + 32768, 16)));
            exp_y.push_back(clamp16(floor_shift(y + 32768, 16)));
        endfunction

        function void check_result(logic signed [15:0] x, logic signed [15:0] y);
            logic signed [15:0] ex, ey;
            if (exp_x.size() == 0) begin
                $error("result with no pending item: x=%0d y=%0d", x, y);
                errors++;
                return;
            end
            ex = exp_x.pop_front();
            ey = exp_y.pop_front();
            if (x !== ex) begin
                $error("x_out: expected %0d, got %0d", ex, x);
                errors++;
            end
            if (y !== ey) begin
                $error("y_out: expected %0d, got %0d", ey, y);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy, o_done, o_cfg_ready;
    logic signed [15:0] i_x_in = '0, i_y_in = '0;
    logic signed [15:0] i_translate_x_cv = '0, i_translate_y_cv = '0;
    logic signed [15:0] i_scale_x_cv = '0, i_scale_y_cv = '0;
    logic signed [15:0] i_skew_x_cv = '0, i_skew_y_cv = '0, i_rotate_cv = '0;
    logic signed [15:0] o_x_out, o_y_out;
    logic               i_cfg_valid = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [62:0]        i_cfg_data = '0;

    affine_scoreboard sb = new();
    bit steady;

    planar_affine_transform u_top (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk)
        if (i_rst_n && o_done) sb.check_result(o_x_out, o_y_out);

    initial begin
        #5ms;
        $display("tb failed");
        $finish;
    end

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 11))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'(int'($urandom_range(0, 4096)) - 2048);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_point_item rand_point();
        t_point_item it;
        it = '{rand_sample(), rand_sample(), rand_sample(), rand_sample(), rand_sample(),
               rand_sample(), rand_sample(), rand_sample(), rand_sample()};
        return it;
    endfunction

    function automatic bit [62:0] rand_depths();
        bit [62:0] v;
        for (int k = 0; k < 7; k++)
            case ($urandom_range(0, 3))
                0:       v[9*k +: 9] = 9'd0;
                1:       v[9*k +: 9] = 9'd256;
                default: v[9*k +: 9] = 9'($urandom);
            endcase
        return v;
    endfunction

    task automatic send_point(t_point_item it);
        int gap;
        i_x_in <= it.x;  i_y_in <= it.y;
        i_translate_x_cv <= it.tx;  i_translate_y_cv <= it.ty;
        i_scale_x_cv <= it.sx;  i_scale_y_cv <= it.sy;
        i_skew_x_cv <= it.kx;  i_skew_y_cv <= it.ky;
        i_rotate_cv <= it.rot;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        sb.note_item(it);
        if (steady) return;
        case ($urandom_range(0, 19))
            0:             gap = $urandom_range(20, 60);
            1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
            default:       gap = 0;
        endcase
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drain the pipeline before touching any register
    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.exp_x.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(paff_pkg::t_reg_idx idx, bit [62:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, v);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(int tx, int ty, int sx, int sy, int kx, int ky, int rot,
                            bit [62:0] dep);
        wait_idle();
        write_reg(paff_pkg::REG_TX, 63'(tx));
        write_reg(paff_pkg::REG_TY, 63'(ty));
        write_reg(paff_pkg::REG_SX, 63'(sx));
        write_reg(paff_pkg::REG_SY, 63'(sy));
        write_reg(paff_pkg::REG_KX, 63'(kx));
        write_reg(paff_pkg::REG_KY, 63'(ky));
        write_reg(paff_pkg::REG_ROT, 63'(rot));
        write_reg(paff_pkg::REG_DEPTHS, dep);
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
            send_point(rand_point());
        end
        steady = 1'b0;
    endtask

    initial begin
        bit [62:0] all256, all511;
        for (int k = 0; k < 7; k++) begin
            all256[9*k +: 9] = 9'd256;
            all511[9*k +: 9] = 9'd511;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: identity transform, corners and zero point
        send_point('{16'sh7fff, 16'sh7fff, 0, 0, 0, 0, 0, 0, 0});
        send_point('{16'sh8000, 16'sh8000, 0, 0, 0, 0, 0, 0, 0});
        send_point('{16'sh7fff, 16'sh8000, 0, 0, 0, 0, 0, 0, 0});
        send_point('{0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                     16'sh8000, 16'sh7fff});
        send_point('{16'sd2048, 16'sd0, 0, 0, 0, 0, 0, 0, 0});
        run_random(40);

        // all cv, full scale and rotation cv at quarter turns
        set_regs(10240, -10240, 32767, 20480, 10240, -10240, 16383, all256);
        for (int q = -4; q <= 4; q++)
            send_point('{16'sd4096, -16'sd2048, 0, 0, 16'sd10240, 16'sd10240, 0, 0,
                         16'(q * 2560)});
        send_point('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                     16'sh7fff, 16'sh7fff, 16'sh7fff});
        send_point('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                     16'sh8000, 16'sh8000, 16'sh8000});
        run_random(60);

        // knob extremes, zero scale
        set_regs(-16384, -16384, 0, 0, -16384, -16384, 0, '0);
        send_point('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                     16'sh7fff, 16'sh7fff, 16'sh7fff});
        run_random(30);

        // upper knob range, depth fields above one
        set_regs(16383, 16383, 32767, 32767, 16383, 16383, 16383, all511);
        run_random(60);
        set_regs(16383, 16383, 32767, 32767, 16383, 16383, 16383, '0);
        run_random(60);

        for (int ph = 0; ph < 6; ph++) begin
            set_regs($urandom, $urandom, $urandom_range(0, 20480), $urandom_range(0, 32767),
                     $urandom, $urandom, $urandom, rand_depths());
            run_random(250);
        end

        wait_idle();
        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
